/* src/moving_window_average_top_assert.svh */
// Assertion macros for the moving window average RTL.
`ifndef MOVING_WINDOW_AVERAGE_TOP_ASSERT_SVH
`define MOVING_WINDOW_AVERAGE_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MWA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define MWA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mwa_pkg.sv */
// Types, constants and helper functions of the moving window average block.
`default_nettype none

package mwa_pkg;

    localparam int RING_DEPTH  = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int LEN_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_BITS + ADDR_W + 1;

    localparam int WIN_W      = 12;
    localparam int BUFLEN_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int TICK_W     = 14;

    localparam logic [TICK_W-1:0] TICK_LAST = 14'd9999;

    localparam logic [WIN_W-1:0]    WIN_RESET    = 12'd1;
    localparam logic [BUFLEN_W-1:0] BUFLEN_RESET = 7'd10;

    localparam logic [CFG_IDX_W-1:0] REG_REQ_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_LEN    = 2'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_enable;
        logic                          average_on;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average_out;
        logic                          enable_out;
        logic                          average_active;
        logic [TICK_W-1:0]             tick_count;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
        logic [LEN_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [LEN_W-1:0] n;
        logic             in_range;
    } window_t;

    // Ring entries in use, clamped to 1..RING_DEPTH.
    function automatic logic [LEN_W-1:0] eff_len(input logic [BUFLEN_W-1:0] bl);
        logic [LEN_W-1:0] len;
        if (bl == '0)
            len = LEN_W'(1);
        else if (int'(bl) > RING_DEPTH)
            len = LEN_W'(RING_DEPTH);
        else
            len = LEN_W'(bl);
        return len;
    endfunction

    // Window clamped to 1..len; flag drops whenever a clamp applies.
    function automatic window_t clamp_window(input logic [WIN_W-1:0] rw,
                                             input logic [LEN_W-1:0] len);
        window_t w;
        if (int'(rw) > int'(len)) begin
            w.n        = len;
            w.in_range = 1'b0;
        end else if (rw == '0) begin
            w.n        = LEN_W'(1);
            w.in_range = 1'b0;
        end else begin
            w.n        = LEN_W'(rw);
            w.in_range = 1'b1;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* src/mwa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/mwa_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none

module mwa_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mwa_pkg::div_req_t req,
    output mwa_pkg::div_rsp_t      rsp
);
    import mwa_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] dvd_reg;
    logic [LEN_W-1:0] dsr_reg;
    logic [LEN_W-1:0] rem_reg;

    logic [LEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                busy_reg <= cnt_reg != CNT_W'(1);
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, subtract when it fits
            if (fits)
                rem_reg <= LEN_W'(trial - {1'b0, dsr_reg});
            else
                rem_reg <= trial[LEN_W-1:0];
            dvd_reg <= {dvd_reg[SUM_W-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

/* src/moving_window_average_top.sv */
// Moving window average over a ring of samples held in one RAM.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | in_data: sample, block enable, average on
//  out     | out_valid / out_stall| out_data: average, enable, active, ticks
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (window, length)
//
// One item at a time. Disabled and pass-through items go from S_IDLE through
// S_DONE to the output register; the first averaging item fills the ring first
// (one RAM write per entry), and later averaging items take two passes of the
// bit-serial divider plus one RAM read per window entry.
// Reset clears control state only; ring contents stay undefined until filled.
// A finished result waits in the output register while out_stall is high; the
// next request is taken meanwhile, and its result waits for the slot to free.
`default_nettype none
`include "moving_window_average_top_assert.svh"

module moving_window_average_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire mwa_pkg::in_item_t                in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output mwa_pkg::out_item_t                    out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mwa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mwa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mwa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [WIN_W-1:0]              window_reg;
    logic [BUFLEN_W-1:0]           buflen_reg;
    logic [ADDR_W-1:0]             write_index_reg, write_index_next;
    logic                          started_reg, started_next;
    logic signed [SAMPLE_BITS-1:0] held_output_reg, held_output_next;
    logic                          held_en_reg, held_en_next;
    logic                          held_active_reg, held_active_next;
    logic [TICK_W-1:0]             tick_reg, tick_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [LEN_W-1:0]              len_reg, len_next;
    logic [LEN_W-1:0]              n_reg, n_next;
    logic [ADDR_W-1:0]             addr_reg, addr_next;
    logic [LEN_W-1:0]              cnt_reg, cnt_next;
    logic                          pending_reg, pending_next;
    logic signed [SUM_W-1:0]       acc_reg, acc_next;
    logic                          neg_reg, neg_next;
    logic                          out_valid_reg, out_valid_next;
    out_item_t                     out_data_reg, out_data_next;

    logic                          accept;
    logic                          out_free;
    logic [LEN_W-1:0]              cur_len;
    window_t                       win;
    logic [LEN_W:0]                rem_inc;
    logic [SUM_W-1:0]              acc_mag;
    logic [SUM_W-1:0]              quot_signed;

    logic                          ram_wr_en;
    logic [ADDR_W-1:0]             ram_wr_addr;
    logic [SAMPLE_BITS-1:0]        ram_wr_data;
    logic                          ram_rd_en;
    logic [SAMPLE_BITS-1:0]        ram_rd_data;

    div_req_t                      div_req;
    div_rsp_t                      div_rsp;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cur_len     = eff_len(buflen_reg);
    assign win         = clamp_window(window_reg, cur_len);
    assign rem_inc     = {1'b0, div_rsp.remainder} + (LEN_W + 1)'(1);
    assign acc_mag     = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign quot_signed = neg_reg ? -div_rsp.quotient : div_rsp.quotient;

    mwa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    mwa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        write_index_next = write_index_reg;
        started_next     = started_reg;
        held_output_next = held_output_reg;
        held_en_next     = held_en_reg;
        held_active_next = held_active_reg;
        tick_next        = tick_reg;
        sample_next      = sample_reg;
        len_next         = len_reg;
        n_next           = n_reg;
        addr_next        = addr_reg;
        cnt_next         = cnt_reg;
        pending_next     = 1'b0;
        acc_next         = acc_reg;
        neg_next         = neg_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;

        ram_wr_en        = 1'b0;
        ram_wr_addr      = addr_reg;
        ram_wr_data      = sample_reg;
        ram_rd_en        = 1'b0;

        div_req.start    = 1'b0;
        div_req.dividend = SUM_W'(write_index_reg);
        div_req.divisor  = cur_len;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tick_next   = (tick_reg == TICK_LAST) ? '0 : tick_reg + TICK_W'(1);
                    sample_next = in_data.sample_in;
                    len_next    = cur_len;
                    state_next  = S_DONE;
                    if (!in_data.block_enable)
                    begin
                        held_en_next = 1'b0;
                    end
                    else if (!in_data.average_on)
                    begin
                        held_active_next = 1'b0;
                        held_output_next = in_data.sample_in;
                        started_next     = 1'b0;
                        held_en_next     = 1'b1;
                    end
                    else if (!started_reg)
                    begin
                        held_active_next = 1'b1;
                        addr_next        = '0;
                        state_next       = S_FILL;
                    end
                    else
                    begin
                        // store the new sample, then find its slot modulo len
                        held_active_next = 1'b1;
                        held_en_next     = win.in_range;
                        n_next           = win.n;
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = write_index_reg;
                        ram_wr_data      = in_data.sample_in;
                        div_req.start    = 1'b1;
                        state_next       = S_MOD;
                    end
                end
            end
            S_FILL:
            begin
                ram_wr_en = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
                if (LEN_W'(addr_reg) == len_reg - LEN_W'(1))
                begin
                    started_next     = 1'b1;
                    held_output_next = sample_reg;
                    held_en_next     = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_MOD:
            begin
                if (div_rsp.done)
                begin
                    addr_next = ADDR_W'(div_rsp.remainder);
                    if (rem_inc == {1'b0, len_reg})
                        write_index_next = '0;
                    else
                        write_index_next = ADDR_W'(rem_inc);
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (pending_reg)
                begin
                    acc_next = acc_reg + SUM_W'($signed(ram_rd_data));
                end
                if (cnt_reg != n_reg)
                begin
                    // walk backward through the ring, wrapping at len
                    ram_rd_en    = 1'b1;
                    pending_next = 1'b1;
                    cnt_next     = cnt_reg + LEN_W'(1);
                    if (addr_reg == '0)
                        addr_next = ADDR_W'(len_reg - LEN_W'(1));
                    else
                        addr_next = addr_reg - ADDR_W'(1);
                end
                else if (!pending_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = acc_mag;
                    div_req.divisor  = n_reg;
                    neg_next         = acc_reg[SUM_W-1];
                    state_next       = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    held_output_next = SAMPLE_BITS'(quot_signed);
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.average_out    = held_output_reg;
                    out_data_next.enable_out     = held_en_reg;
                    out_data_next.average_active = held_active_reg;
                    out_data_next.tick_count     = tick_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_reg      <= WIN_RESET;
            buflen_reg      <= BUFLEN_RESET;
            write_index_reg <= '0;
            started_reg     <= 1'b0;
            held_output_reg <= '0;
            held_en_reg     <= 1'b0;
            held_active_reg <= 1'b0;
            tick_reg        <= '0;
            pending_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_index_reg <= write_index_next;
            started_reg     <= started_next;
            held_output_reg <= held_output_next;
            held_en_reg     <= held_en_next;
            held_active_reg <= held_active_next;
            tick_reg        <= tick_next;
            pending_reg     <= pending_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_REQ_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                    REG_BUF_LEN:    buflen_reg <= cfg_data[BUFLEN_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        len_reg      <= len_next;
        n_reg        <= n_next;
        addr_reg     <= addr_next;
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    `MWA_ASSERT_NOW(a_tick_range, 1'b1, tick_reg <= TICK_LAST, "tick counter out of range")
    `MWA_ASSERT_NOW(a_read_in_ring, ram_rd_en, LEN_W'(addr_reg) < len_reg, "read beyond ring length")
    `MWA_ASSERT_NOW(a_div_owner, div_rsp.done, state_reg == S_MOD || state_reg == S_DIV, "divider done outside its states")
    `MWA_ASSERT_NEXT(a_result_loaded, state_reg == S_DONE && out_free, out_valid_reg && state_reg == S_IDLE, "result not loaded")

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the moving window average block: directed and random runs.
`timescale 1ns / 1ps

module tb_top;
    import mwa_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_REQ_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Expected view of the block: configuration, ring and held outputs.
    logic [WIN_W-1:0] window_cfg = WIN_RESET;
    logic [BUFLEN_W-1:0] length_cfg = BUFLEN_RESET;
    logic signed [SAMPLE_BITS-1:0] ring_copy [RING_DEPTH];
    bit slot_filled [RING_DEPTH];
    int write_slot = 0;
    bit averaging_live = 1'b0;
    logic signed [SAMPLE_BITS-1:0] held_average = '0;
    bit enable_now = 1'b0;
    bit active_now = 1'b0;
    logic [TICK_W-1:0] tick_total = '0;

    out_item_t pending_averages [$];

    int items_sent = 0;
    int results_checked = 0;
    int config_writes = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    bit sender_live = 1'b0;
    int burst_left = 0;
    int max_gap = 8;

    int stall_mode = 0;
    int stall_phase_left = 0;
    int stall_run = 0;

    moving_window_average_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("moving_window_average_top: mismatch");
            $finish;
        end
    end

    // Output stall: alternate between no stall, random stall and long runs.
    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_phase_left = $urandom_range(32, 400);
        end
        else
            stall_phase_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_run == 0)
                begin
                    out_stall <= ~out_stall;
                    stall_run = $urandom_range(1, 16);
                end
                else
                    stall_run--;
            end
        endcase
    end

    function automatic int ring_len();
        if (length_cfg == '0)
            return 1;
        if (int'(length_cfg) > RING_DEPTH)
            return RING_DEPTH;
        return int'(length_cfg);
    endfunction

    function automatic int window_size();
        int len;
        len = ring_len();
        if (int'(window_cfg) > len)
            return len;
        if (window_cfg == '0)
            return 1;
        return int'(window_cfg);
    endfunction

    // True when this averaging tick would sum a ring entry never written.
    function automatic bit reads_unfilled(in_item_t item);
        int len;
        int pos;
        if (!item.block_enable || !item.average_on || !averaging_live)
            return 1'b0;
        len = ring_len();
        for (int d = 0; d < window_size(); d++)
        begin
            pos = (write_slot - d) % len;
            if (pos < 0)
                pos += len;
            if (pos != write_slot && !slot_filled[pos])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic out_item_t advance_average(in_item_t item);
        out_item_t res;
        int len;
        int n;
        int pos;
        longint total;
        len = ring_len();
        if (item.block_enable)
        begin
            active_now = item.average_on;
            if (!item.average_on)
            begin
                held_average = item.sample_in;
                averaging_live = 1'b0;
                enable_now = 1'b1;
            end
            else if (!averaging_live)
            begin
                // first averaging tick: fill the ring with this sample
                for (int i = 0; i < len; i++)
                begin
                    ring_copy[i] = item.sample_in;
                    slot_filled[i] = 1'b1;
                end
                averaging_live = 1'b1;
                held_average = item.sample_in;
                enable_now = 1'b1;
            end
            else
            begin
                n = window_size();
                enable_now = (int'(window_cfg) == n);
                ring_copy[write_slot] = item.sample_in;
                slot_filled[write_slot] = 1'b1;
                total = 0;
                for (int d = 0; d < n; d++)
                begin
                    pos = (write_slot - d) % len;
                    if (pos < 0)
                        pos += len;
                    total += ring_copy[pos];
                end
                held_average = SAMPLE_BITS'(total / n);
                write_slot = (write_slot + 1) % len;
            end
        end
        else
            enable_now = 1'b0;
        tick_total = (tick_total == TICK_LAST) ? '0 : tick_total + 1'b1;
        res.average_out = held_average;
        res.enable_out = enable_now;
        res.average_active = active_now;
        res.tick_count = tick_total;
        return res;
    endfunction

    function automatic void note_mismatch(string field, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (mismatch_count < 10)
            $display("result %0d %s: expected %0d, got %0d", results_checked, field, want, got);
        mismatch_count++;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_averages.size() == 0)
                note_mismatch("unexpected result, average_out", 0, out_data.average_out);
            else
            begin
                want = pending_averages.pop_front();
                if (out_data.average_out !== want.average_out)
                    note_mismatch("average_out", want.average_out, out_data.average_out);
                if (out_data.enable_out !== want.enable_out)
                    note_mismatch("enable_out", want.enable_out, out_data.enable_out);
                if (out_data.average_active !== want.average_active)
                    note_mismatch("average_active", want.average_active,
                                  out_data.average_active);
                if (out_data.tick_count !== want.tick_count)
                    note_mismatch("tick_count", want.tick_count, out_data.tick_count);
            end
            results_checked++;
        end
    end

    function automatic in_item_t tick_item(logic signed [SAMPLE_BITS-1:0] sample, bit en,
                                           bit avon);
        in_item_t item;
        item.sample_in = sample;
        item.block_enable = en;
        item.average_on = avon;
        return item;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return SAMPLE_BITS'($urandom_range(0, 15)) - 16'sd8;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic send_sample(in_item_t item);
        // turn a request that would sum unwritten entries into a pass-through
        if (reads_unfilled(item))
            item.average_on = 1'b0;
        in_valid <= 1'b1;
        in_data <= item;
        sender_live = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_averages.push_back(advance_average(item));
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            sender_live = 1'b0;
            repeat ($urandom_range(1, max_gap)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Hold the sender until every expected result is out.
    task automatic drain_results();
        if (sender_live)
        begin
            in_valid <= 1'b0;
            sender_live = 1'b0;
        end
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_REQ_WINDOW)
            window_cfg = value[WIN_W-1:0];
        else if (idx == REG_BUF_LEN)
            length_cfg = value[BUFLEN_W-1:0];
        config_writes++;
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] win_value, logic [CFG_DATA_W-1:0] len_value);
        drain_results();
        write_register(REG_REQ_WINDOW, win_value);
        write_register(REG_BUF_LEN, len_value);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        // reset settings: window 1 over 10 entries
        send_sample(tick_item(16'sh7FFF, 1'b0, 1'b0));
        send_sample(tick_item(16'sh7FFF, 1'b1, 1'b0));
        send_sample(tick_item(16'sh8000, 1'b1, 1'b0));
        send_sample(tick_item(16'sh0000, 1'b1, 1'b0));
        send_sample(tick_item(16'sh1234, 1'b0, 1'b1));
        send_sample(tick_item(-16'sd1, 1'b1, 1'b1));
        send_sample(tick_item(16'sh8000, 1'b1, 1'b1));

        // truncation toward zero on negative sums, then a disabled tick
        configure(12'd4, 12'd4);
        send_sample(tick_item(16'sh0000, 1'b1, 1'b0));
        send_sample(tick_item(16'sh0000, 1'b1, 1'b1));
        send_sample(tick_item(-16'sd1, 1'b1, 1'b1));
        send_sample(tick_item(-16'sd2, 1'b1, 1'b1));
        send_sample(tick_item(16'sd3, 1'b1, 1'b1));
        send_sample(tick_item(16'sh7FFF, 1'b0, 1'b0));

        // window clamped below and above
        configure(12'd0, 12'd4);
        send_sample(tick_item(16'sd5, 1'b1, 1'b1));
        configure(12'd4095, 12'd4);
        send_sample(tick_item(-16'sd5, 1'b1, 1'b1));

        // shrink the ring while averaging
        configure(12'd2, 12'd10);
        send_sample(tick_item(16'sd0, 1'b1, 1'b0));
        send_sample(tick_item(16'sd100, 1'b1, 1'b1));
        send_sample(tick_item(16'sd200, 1'b1, 1'b1));
        send_sample(tick_item(-16'sd300, 1'b1, 1'b1));
        send_sample(tick_item(16'sd7, 1'b1, 1'b1));
        configure(12'd2, 12'd3);
        send_sample(tick_item(16'sd11, 1'b1, 1'b1));
        send_sample(tick_item(16'sd12, 1'b1, 1'b1));

        // zero length clamps to one, oversize length clamps to the ring depth
        configure(12'd1, 12'd0);
        send_sample(tick_item(-16'sd7, 1'b1, 1'b1));
        configure(12'd64, 12'd127);
        send_sample(tick_item(16'sd1, 1'b1, 1'b0));
        send_sample(tick_item(16'sh8000, 1'b1, 1'b1));
        send_sample(tick_item(16'sh7FFF, 1'b1, 1'b1));
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] win_value;
        logic [BUFLEN_W-1:0] len_value;
        int pick;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 5))
                0: win_value = '0;
                1: win_value = 12'd4095;
                2: win_value = CFG_DATA_W'($urandom_range(0, 4095));
                default: win_value = CFG_DATA_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 5))
                0: len_value = '0;
                1: len_value = 7'd127;
                2: len_value = 7'd64;
                3: len_value = BUFLEN_W'($urandom_range(65, 127));
                default: len_value = BUFLEN_W'($urandom_range(1, 16));
            endcase
            max_gap = (phase % 2 == 0) ? 8 : 120;
            configure(win_value, {5'($urandom_range(0, 31)), len_value});
            for (int i = 0; i < 125; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_sample(tick_item(random_sample(), 1'b1, 1'b1));
                else if (pick < 88)
                    send_sample(tick_item(random_sample(), 1'b1, 1'b0));
                else
                    send_sample(tick_item(random_sample(), 1'b0, 1'($urandom_range(0, 1))));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_copy[i] = '0;
            slot_filled[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phases();

        drain_results();
        repeat (20) @(posedge clk);
        $display("%0d samples sent, %0d results checked, %0d register writes",
                 items_sent, results_checked, config_writes);
        $display("covered pass-through, ring fill, window clamps, length changes, stalls");
        if (mismatch_count == 0 && pending_averages.size() == 0)
            $display("moving_window_average_top: match");
        else
            $display("moving_window_average_top: mismatch");
        $finish;
    end

endmodule
